/* hdl/ldm_pkg.sv */
// ----------------------------------------------------------------------------
// ldm_pkg: shared definitions for the label dilation core
// Slice limits, field widths, command and status codes, register indexes,
// and the store access bundle passed between the sequencer and the top level.
// ----------------------------------------------------------------------------
package ldm_pkg;

  localparam int MAX_WIDTH   = 256;
  localparam int MAX_HEIGHT  = 256;
  localparam int LABEL_BITS  = 32;
  localparam int STORE_DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  localparam int COL_W       = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int ROW_W       = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int DIM_W       = 9;
  localparam int NPIX_W      = 2 * DIM_W;
  localparam int DIST_W      = 9;

  localparam logic [DIST_W-1:0] DIST_MAX = '1;
  localparam logic [DIM_W-1:0]  DIM_MAX_W = DIM_W'(MAX_WIDTH);
  localparam logic [DIM_W-1:0]  DIM_MAX_H = DIM_W'(MAX_HEIGHT);

  // Command codes; code 3 is unused and answered as out of range.
  typedef enum logic [1:0] {
    OP_LOAD = 2'd0,
    OP_RUN  = 2'd1,
    OP_READ = 2'd2
  } opcode_t;

  typedef enum logic [1:0] {
    ST_LOADED = 2'd0,
    ST_DONE   = 2'd1,
    ST_READ   = 2'd2,
    ST_RANGE  = 2'd3
  } status_t;

  localparam logic [1:0] CFG_WIDTH  = 2'd0;
  localparam logic [1:0] CFG_HEIGHT = 2'd1;
  localparam logic [1:0] CFG_DILATE = 2'd2;

  // Store traffic bundle: two read addresses, one write.
  typedef struct packed {
    logic [ADDR_W-1:0]     rd_addr0;
    logic [ADDR_W-1:0]     rd_addr1;
    logic                  we_label;
    logic                  we_dist;
    logic [ADDR_W-1:0]     wr_addr;
    logic [LABEL_BITS-1:0] wr_label;
    logic [DIST_W-1:0]     wr_dist;
  } mem_req_t;

endpackage

/* hdl/label_dilation_manhattan_core.sv */
// ----------------------------------------------------------------------------
// label_dilation_manhattan_core: city-block distance transform and dilation
// Load, transform and read commands over one slice of segment labels.
// ----------------------------------------------------------------------------
// A load or a read gives its result item in the cycle after acceptance.
// A transform over width * height pixels keeps busy high and strobes its
// result in the cycle busy drops; the two raster passes share the
// single relaxation unit, one pass after the other.
// Throughput: one load or read item per cycle while busy is low; the receiver cannot stall.
// Reset clears the registers to 256 x 256 with dilate_k zero; the stores are
// not cleared and hold nothing meaningful until written.
// ----------------------------------------------------------------------------
module label_dilation_manhattan_core (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  input  logic [1:0]                     opcode,
  input  logic [15:0]                    pixel_index,
  input  logic [31:0]                    label_in,
  output logic                           done,
  output logic [1:0]                     status,
  output logic [31:0]                    nearest_label,
  output logic [8:0]                     distance,
  output logic [31:0]                    dilated_label,
  input  logic                           cfg_we,
  input  logic [1:0]                     cfg_index,
  input  logic [8:0]                     cfg_data
);

  // Configuration registers.
  logic [ldm_pkg::DIM_W-1:0]      slice_width;
  logic [ldm_pkg::DIM_W-1:0]      slice_height;
  logic [ldm_pkg::DIST_W-1:0]     dilate_k;

  // Sizes clamped into the range the stores can hold; zero acts as one.
  logic [ldm_pkg::DIM_W-1:0]      eff_w;
  logic [ldm_pkg::DIM_W-1:0]      eff_h;
  logic [ldm_pkg::NPIX_W-1:0]     npix;
  logic                           in_range;
  logic                           accept;

  // Result registers. show_read marks a read result, whose data comes
  // straight from the registered read port of the stores.
  logic                           show_read;
  ldm_pkg::status_t               status_reg;

  ldm_pkg::mem_req_t              sweep_req;
  ldm_pkg::mem_req_t              mem_req;
  logic                           sweep_active;
  logic                           sweep_fin;
  logic [ldm_pkg::LABEL_BITS-1:0] rd_label0;
  logic [ldm_pkg::DIST_W-1:0]     rd_dist0;
  logic [ldm_pkg::LABEL_BITS-1:0] rd_label1;
  logic [ldm_pkg::DIST_W-1:0]     rd_dist1;

  always_comb begin
    if (slice_width == '0) begin
      eff_w = ldm_pkg::DIM_W'(1);
    end else if (slice_width > ldm_pkg::DIM_MAX_W) begin
      eff_w = ldm_pkg::DIM_MAX_W;
    end else begin
      eff_w = slice_width;
    end
    if (slice_height == '0) begin
      eff_h = ldm_pkg::DIM_W'(1);
    end else if (slice_height > ldm_pkg::DIM_MAX_H) begin
      eff_h = ldm_pkg::DIM_MAX_H;
    end else begin
      eff_h = slice_height;
    end
  end

  assign npix     = ldm_pkg::NPIX_W'(eff_w) * ldm_pkg::NPIX_W'(eff_h);
  assign in_range = (ldm_pkg::NPIX_W'(pixel_index) < npix);

  // The sequencer leaves idle at the edge that takes a transform item, so
  // busy follows it directly.
  assign busy   = sweep_active;
  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      slice_width  <= ldm_pkg::DIM_W'(ldm_pkg::MAX_WIDTH);
      slice_height <= ldm_pkg::DIM_W'(ldm_pkg::MAX_HEIGHT);
      dilate_k     <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        ldm_pkg::CFG_WIDTH:  slice_width  <= cfg_data;
        ldm_pkg::CFG_HEIGHT: slice_height <= cfg_data;
        ldm_pkg::CFG_DILATE: dilate_k     <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Store port ownership: the sequencer during a transform, otherwise the
  // command side. A load writes only the label store; outside a transform the
  // read port follows pixel_index so a read item sees its data in the next cycle.
  always_comb begin
    if (sweep_active) begin
      mem_req = sweep_req;
    end else begin
      mem_req.rd_addr0 = pixel_index;
      mem_req.rd_addr1 = pixel_index;
      mem_req.we_label = accept && (opcode == ldm_pkg::OP_LOAD) && in_range;
      mem_req.we_dist  = 1'b0;
      mem_req.wr_addr  = pixel_index;
      mem_req.wr_label = label_in[ldm_pkg::LABEL_BITS-1:0];
      mem_req.wr_dist  = ldm_pkg::DIST_MAX;
    end
  end

  ldm_store u_store (
    .clk       (clk),
    .req       (mem_req),
    .rd_label0 (rd_label0),
    .rd_dist0  (rd_dist0),
    .rd_label1 (rd_label1),
    .rd_dist1  (rd_dist1)
  );

  ldm_sweep u_sweep (
    .clk       (clk),
    .rst       (rst),
    .go        (accept && (opcode == ldm_pkg::OP_RUN)),
    .eff_w     (eff_w),
    .eff_h     (eff_h),
    .npix      (npix),
    .rd_label0 (rd_label0),
    .rd_dist0  (rd_dist0),
    .rd_label1 (rd_label1),
    .rd_dist1  (rd_dist1),
    .req       (sweep_req),
    .active    (sweep_active),
    .fin       (sweep_fin)
  );

  // Result sequencing. A load or read answers at once; a transform answers
  // at the edge that writes the last pixel of the backward pass. An unused
  // opcode or an index past the slice answers out of range.
  always_ff @(posedge clk) begin
    if (rst) begin
      done       <= 1'b0;
      show_read  <= 1'b0;
      status_reg <= ldm_pkg::ST_RANGE;
    end else begin
      done      <= 1'b0;
      show_read <= 1'b0;
      if (sweep_fin) begin
        done       <= 1'b1;
        status_reg <= ldm_pkg::ST_DONE;
      end else if (accept) begin
        priority if (opcode == ldm_pkg::OP_LOAD && in_range) begin
          done       <= 1'b1;
          status_reg <= ldm_pkg::ST_LOADED;
        end else if (opcode == ldm_pkg::OP_READ && in_range) begin
          done       <= 1'b1;
          show_read  <= 1'b1;
          status_reg <= ldm_pkg::ST_READ;
        end else if (opcode == ldm_pkg::OP_RUN) begin
          // Answered when the passes finish.
          done <= 1'b0;
        end else begin
          done       <= 1'b1;
          status_reg <= ldm_pkg::ST_RANGE;
        end
      end
    end
  end

  // Only a read result carries data; every other result reads zero.
  assign status        = status_reg;
  assign nearest_label = show_read ? 32'(rd_label0) : '0;
  assign distance      = show_read ? rd_dist0 : '0;
  assign dilated_label = (show_read && !(rd_dist0 > dilate_k)) ? 32'(rd_label0) : '0;

endmodule

/* hdl/ldm_relax.sv */
// ----------------------------------------------------------------------------
// ldm_relax: neighbor relaxation unit
// Takes the neighbor's distance plus one and its label when the neighbor is
// strictly closer than the pixel under work.
// ----------------------------------------------------------------------------
module ldm_relax (
  input  logic [ldm_pkg::DIST_W-1:0]     here_dist,
  input  logic [ldm_pkg::LABEL_BITS-1:0] here_label,
  input  logic                           nb_valid,
  input  logic [ldm_pkg::DIST_W-1:0]     nb_dist,
  input  logic [ldm_pkg::LABEL_BITS-1:0] nb_label,
  output logic [ldm_pkg::DIST_W-1:0]     out_dist,
  output logic [ldm_pkg::LABEL_BITS-1:0] out_label
);

  logic take;

  // A closer neighbor is below 511, so the increment cannot wrap.
  assign take      = nb_valid && (nb_dist < here_dist);
  assign out_dist  = take ? nb_dist + ldm_pkg::DIST_W'(1) : here_dist;
  assign out_label = take ? nb_label : here_label;

endmodule

/* hdl/ldm_store.sv */
// ----------------------------------------------------------------------------
// ldm_store: label and distance memories
// Two registered read ports and one write port on each memory.
// ----------------------------------------------------------------------------
module ldm_store (
  input  logic                           clk,
  input  ldm_pkg::mem_req_t              req,
  output logic [ldm_pkg::LABEL_BITS-1:0] rd_label0,
  output logic [ldm_pkg::DIST_W-1:0]     rd_dist0,
  output logic [ldm_pkg::LABEL_BITS-1:0] rd_label1,
  output logic [ldm_pkg::DIST_W-1:0]     rd_dist1
);

  logic [ldm_pkg::LABEL_BITS-1:0] label_mem [ldm_pkg::STORE_DEPTH];
  logic [ldm_pkg::DIST_W-1:0]     dist_mem  [ldm_pkg::STORE_DEPTH];

  always_ff @(posedge clk) begin
    if (req.we_label) begin
      label_mem[req.wr_addr] <= req.wr_label;
    end
    rd_label0 <= label_mem[req.rd_addr0];
    rd_label1 <= label_mem[req.rd_addr1];
  end

  always_ff @(posedge clk) begin
    if (req.we_dist) begin
      dist_mem[req.wr_addr] <= req.wr_dist;
    end
    rd_dist0 <= dist_mem[req.rd_addr0];
    rd_dist1 <= dist_mem[req.rd_addr1];
  end

endmodule

/* hdl/ldm_sweep.sv */
// ----------------------------------------------------------------------------
// ldm_sweep: raster pass sequencer
// Runs the forward and the backward pass through one shared relaxation
// unit, taking each pixel's vertical neighbor first, then its horizontal neighbor.
// ----------------------------------------------------------------------------
module ldm_sweep (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           go,
  input  logic [ldm_pkg::DIM_W-1:0]      eff_w,
  input  logic [ldm_pkg::DIM_W-1:0]      eff_h,
  input  logic [ldm_pkg::NPIX_W-1:0]     npix,
  input  logic [ldm_pkg::LABEL_BITS-1:0] rd_label0,
  input  logic [ldm_pkg::DIST_W-1:0]     rd_dist0,
  input  logic [ldm_pkg::LABEL_BITS-1:0] rd_label1,
  input  logic [ldm_pkg::DIST_W-1:0]     rd_dist1,
  output ldm_pkg::mem_req_t              req,
  output logic                           active,
  output logic                           fin
);

  typedef enum logic [1:0] {
    SW_IDLE,
    SW_PRIME,
    SW_VERT,
    SW_HORZ
  } sw_state_t;

  sw_state_t                      state;
  logic                           bwd;
  logic [ldm_pkg::ADDR_W-1:0]     cp;
  logic [ldm_pkg::ROW_W-1:0]      cr;
  logic [ldm_pkg::COL_W-1:0]      cc;
  logic [ldm_pkg::DIST_W-1:0]     acc_dist;
  logic [ldm_pkg::LABEL_BITS-1:0] acc_label;
  logic [ldm_pkg::DIST_W-1:0]     prev_dist;
  logic [ldm_pkg::LABEL_BITS-1:0] prev_label;

  logic [ldm_pkg::DIM_W-1:0]      w_m1;
  logic [ldm_pkg::DIM_W-1:0]      h_m1;
  logic [ldm_pkg::NPIX_W-1:0]     npix_m1;
  logic                           row_first;
  logic                           row_last;
  logic                           col_first;
  logic                           col_last;
  logic                           at_end;
  logic [ldm_pkg::ADDR_W-1:0]     np;
  logic [ldm_pkg::ROW_W-1:0]      nr;
  logic [ldm_pkg::COL_W-1:0]      nc;
  logic [ldm_pkg::ADDR_W-1:0]     base;
  logic [ldm_pkg::ADDR_W-1:0]     w_step;
  logic                           vert_ok;
  logic                           horz_ok;
  logic [ldm_pkg::DIST_W-1:0]     init_dist;
  logic [ldm_pkg::DIST_W-1:0]     vert_dist;
  logic [ldm_pkg::LABEL_BITS-1:0] vert_label;
  logic [ldm_pkg::DIST_W-1:0]     op_here_dist;
  logic [ldm_pkg::LABEL_BITS-1:0] op_here_label;
  logic                           op_nb_valid;
  logic [ldm_pkg::DIST_W-1:0]     op_nb_dist;
  logic [ldm_pkg::LABEL_BITS-1:0] op_nb_label;
  logic [ldm_pkg::DIST_W-1:0]     r_dist;
  logic [ldm_pkg::LABEL_BITS-1:0] r_label;

  assign w_m1    = eff_w - ldm_pkg::DIM_W'(1);
  assign h_m1    = eff_h - ldm_pkg::DIM_W'(1);
  assign npix_m1 = npix - ldm_pkg::NPIX_W'(1);
  assign w_step  = ldm_pkg::ADDR_W'(eff_w);

  assign row_first = (cr == '0);
  assign row_last  = (ldm_pkg::DIM_W'(cr) == h_m1);
  assign col_first = (cc == '0);
  assign col_last  = (ldm_pkg::DIM_W'(cc) == w_m1);

  assign at_end  = bwd ? (cp == '0) : (row_last && col_last);
  assign vert_ok = bwd ? !row_last : !row_first;
  assign horz_ok = bwd ? !col_last : !col_first;

  // Next pixel in raster order for the pass in progress.
  always_comb begin
    if (bwd) begin
      np = cp - ldm_pkg::ADDR_W'(1);
      nr = col_first ? cr - ldm_pkg::ROW_W'(1) : cr;
      nc = col_first ? w_m1[ldm_pkg::COL_W-1:0] : cc - ldm_pkg::COL_W'(1);
    end else begin
      np = cp + ldm_pkg::ADDR_W'(1);
      nr = col_last ? cr + ldm_pkg::ROW_W'(1) : cr;
      nc = col_last ? '0 : cc + ldm_pkg::COL_W'(1);
    end
  end

  // Reads go out for the pixel that is about to be worked on.
  assign base = (state == SW_PRIME) ? cp : np;

  always_comb begin
    req.rd_addr0 = base;
    req.rd_addr1 = bwd ? base + w_step : base - w_step;
    req.we_label = (state == SW_HORZ);
    req.we_dist  = (state == SW_HORZ);
    req.wr_addr  = cp;
    req.wr_label = r_label;
    req.wr_dist  = r_dist;
  end

  // The forward pass seeds each pixel from its own label; the backward pass
  // starts from what the forward pass left.
  assign init_dist = bwd ? rd_dist0 :
                     ((rd_label0 != '0) ? '0 : ldm_pkg::DIST_MAX);

  // In a one-column slice the vertical neighbor is the pixel written in the
  // same cycle its read went out, so take it from the held copy instead.
  assign vert_dist  = (eff_w == ldm_pkg::DIM_W'(1)) ? prev_dist  : rd_dist1;
  assign vert_label = (eff_w == ldm_pkg::DIM_W'(1)) ? prev_label : rd_label1;

  always_comb begin
    if (state == SW_HORZ) begin
      op_here_dist  = acc_dist;
      op_here_label = acc_label;
      op_nb_valid   = horz_ok;
      op_nb_dist    = prev_dist;
      op_nb_label   = prev_label;
    end else begin
      op_here_dist  = init_dist;
      op_here_label = rd_label0;
      op_nb_valid   = vert_ok;
      op_nb_dist    = vert_dist;
      op_nb_label   = vert_label;
    end
  end

  ldm_relax u_relax (
    .here_dist  (op_here_dist),
    .here_label (op_here_label),
    .nb_valid   (op_nb_valid),
    .nb_dist    (op_nb_dist),
    .nb_label   (op_nb_label),
    .out_dist   (r_dist),
    .out_label  (r_label)
  );

  assign active = (state != SW_IDLE);
  assign fin    = (state == SW_HORZ) && bwd && at_end;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= SW_IDLE;
      bwd   <= 1'b0;
    end else begin
      unique case (state)
        SW_IDLE: begin
          if (go) begin
            bwd   <= 1'b0;
            cp    <= '0;
            cr    <= '0;
            cc    <= '0;
            state <= SW_PRIME;
          end
        end
        SW_PRIME: begin
          state <= SW_VERT;
        end
        SW_VERT: begin
          acc_dist  <= r_dist;
          acc_label <= r_label;
          state     <= SW_HORZ;
        end
        SW_HORZ: begin
          prev_dist  <= r_dist;
          prev_label <= r_label;
          if (at_end) begin
            if (bwd) begin
              state <= SW_IDLE;
            end else begin
              bwd   <= 1'b1;
              cp    <= npix_m1[ldm_pkg::ADDR_W-1:0];
              cr    <= h_m1[ldm_pkg::ROW_W-1:0];
              cc    <= w_m1[ldm_pkg::COL_W-1:0];
              state <= SW_PRIME;
            end
          end else begin
            cp    <= np;
            cr    <= nr;
            cc    <= nc;
            state <= SW_VERT;
          end
        end
        default: begin
          state <= SW_IDLE;
        end
      endcase
    end
  end

endmodule
